// ===== design/xbug_pkg.sv =====
// Shared types and constants for the bounded uniform xoshiro generator.
`timescale 1ns / 1ps

package xbug_pkg;

    localparam int BOUND_BITS_DEF = 32;
    localparam int WORD_BITS      = 64;
    localparam int CNT_BITS       = 6;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

    localparam logic [CNT_BITS-1:0] DIV_LAST  = 6'd63;
    localparam logic [1:0]          WORD_LAST = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MIX1,
        ST_MA0,
        ST_MA1,
        ST_MA2,
        ST_MIX2,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_MIX3,
        ST_THR_INIT,
        ST_THR_DIV,
        ST_THR_SAVE,
        ST_DRAW,
        ST_TEST,
        ST_RES_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEED_INIT,
        OP_MIX1,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_MIX2,
        OP_MIX3,
        OP_DIV_THR,
        OP_DIV_RES,
        OP_DIV_STEP,
        OP_SAVE_THR,
        OP_DRAW,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       mul_b;
        logic [1:0] word_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic bound_zero;
        logic below_thr;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/xbug_ctrl.sv =====
// Sequencer for seeding, threshold and remainder division and rejection draws.
`timescale 1ns / 1ps

module xbug_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 cfg_fire,
    output logic                 cfg_ready,
    input  xbug_pkg::dp_status_t status,
    output xbug_pkg::dp_cmd_t    cmd
);

    xbug_pkg::state_t              state_reg, state_next;
    logic [xbug_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                          pend_reg, pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= xbug_pkg::ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        s_ready      = 1'b0;
        cfg_ready    = 1'b0;
        cmd.op       = xbug_pkg::OP_NONE;
        cmd.mul_b    = 1'b0;
        cmd.word_idx = cnt_reg[1:0];

        case (state_reg)
            xbug_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                cfg_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = xbug_pkg::OP_LOAD;
                    state_next = xbug_pkg::ST_CHECK;
                end
            end
            xbug_pkg::ST_CHECK: begin
                if (status.bound_zero) begin
                    state_next = xbug_pkg::ST_FINISH;
                end else if (pend_reg) begin
                    cmd.op     = xbug_pkg::OP_SEED_INIT;
                    cnt_next   = '0;
                    state_next = xbug_pkg::ST_MIX1;
                end else begin
                    state_next = xbug_pkg::ST_THR_INIT;
                end
            end
            xbug_pkg::ST_MIX1: begin
                cmd.op     = xbug_pkg::OP_MIX1;
                state_next = xbug_pkg::ST_MA0;
            end
            xbug_pkg::ST_MA0: begin
                cmd.op     = xbug_pkg::OP_MUL0;
                state_next = xbug_pkg::ST_MA1;
            end
            xbug_pkg::ST_MA1: begin
                cmd.op     = xbug_pkg::OP_MUL1;
                state_next = xbug_pkg::ST_MA2;
            end
            xbug_pkg::ST_MA2: begin
                cmd.op     = xbug_pkg::OP_MUL2;
                state_next = xbug_pkg::ST_MIX2;
            end
            xbug_pkg::ST_MIX2: begin
                cmd.op     = xbug_pkg::OP_MIX2;
                state_next = xbug_pkg::ST_MB0;
            end
            xbug_pkg::ST_MB0: begin
                cmd.op     = xbug_pkg::OP_MUL0;
                cmd.mul_b  = 1'b1;
                state_next = xbug_pkg::ST_MB1;
            end
            xbug_pkg::ST_MB1: begin
                cmd.op     = xbug_pkg::OP_MUL1;
                cmd.mul_b  = 1'b1;
                state_next = xbug_pkg::ST_MB2;
            end
            xbug_pkg::ST_MB2: begin
                cmd.op     = xbug_pkg::OP_MUL2;
                cmd.mul_b  = 1'b1;
                state_next = xbug_pkg::ST_MIX3;
            end
            xbug_pkg::ST_MIX3: begin
                cmd.op = xbug_pkg::OP_MIX3;
                if (cnt_reg[1:0] == xbug_pkg::WORD_LAST) begin
                    pend_next  = 1'b0;
                    state_next = xbug_pkg::ST_THR_INIT;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = xbug_pkg::ST_MIX1;
                end
            end
            xbug_pkg::ST_THR_INIT: begin
                cmd.op     = xbug_pkg::OP_DIV_THR;
                cnt_next   = '0;
                state_next = xbug_pkg::ST_THR_DIV;
            end
            xbug_pkg::ST_THR_DIV: begin
                cmd.op   = xbug_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == xbug_pkg::DIV_LAST) begin
                    state_next = xbug_pkg::ST_THR_SAVE;
                end
            end
            xbug_pkg::ST_THR_SAVE: begin
                cmd.op     = xbug_pkg::OP_SAVE_THR;
                state_next = xbug_pkg::ST_DRAW;
            end
            xbug_pkg::ST_DRAW: begin
                cmd.op     = xbug_pkg::OP_DRAW;
                state_next = xbug_pkg::ST_TEST;
            end
            xbug_pkg::ST_TEST: begin
                if (status.below_thr) begin
                    state_next = xbug_pkg::ST_DRAW;
                end else begin
                    cmd.op     = xbug_pkg::OP_DIV_RES;
                    cnt_next   = '0;
                    state_next = xbug_pkg::ST_RES_DIV;
                end
            end
            xbug_pkg::ST_RES_DIV: begin
                cmd.op   = xbug_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == xbug_pkg::DIV_LAST) begin
                    state_next = xbug_pkg::ST_FINISH;
                end
            end
            xbug_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.op     = xbug_pkg::OP_OUT;
                    state_next = xbug_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = xbug_pkg::ST_IDLE;
            end
        endcase

        if (cfg_fire) begin
            pend_next = 1'b1;
        end
    end

endmodule

// ===== design/xbug_dp.sv =====
// Datapath: seed expansion, xoshiro256** state, radix-2 remainder unit, output register.
`timescale 1ns / 1ps

module xbug_dp #(
    parameter int BOUND_BITS = xbug_pkg::BOUND_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [BOUND_BITS-1:0]  s_bound,
    input  logic                   cfg_fire,
    input  logic [63:0]            cfg_seed_value,
    input  xbug_pkg::dp_cmd_t      cmd,
    output xbug_pkg::dp_status_t   status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [BOUND_BITS-1:0]  m_value
);

    logic [63:0]           seed_reg;
    logic [63:0]           walker_reg, walker_next;
    logic [63:0]           z_reg, z_next;
    logic [63:0]           acc_reg, acc_next;
    logic [63:0]           gen_reg [4];
    logic [63:0]           gen_next [4];
    logic [63:0]           r_reg, r_next;
    logic [63:0]           dvd_reg, dvd_next;
    logic [BOUND_BITS-1:0] rem_reg, rem_next;
    logic [BOUND_BITS-1:0] bound_reg;
    logic [BOUND_BITS-1:0] thr_reg;
    logic [BOUND_BITS-1:0] value_reg;
    logic                  valid_reg, valid_next;

    logic [63:0]           mul_const;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           prod;
    logic [63:0]           gamma_sum;
    logic [BOUND_BITS:0]   div_trial, div_diff;
    logic [63:0]           m5, rot7, draw_out;
    logic [63:0]           x2, x3;

    assign mul_const = cmd.mul_b ? xbug_pkg::MIX_MUL_B : xbug_pkg::MIX_MUL_A;
    assign gamma_sum = walker_reg + xbug_pkg::GOLDEN_GAMMA;

    always_comb begin
        case (cmd.op)
            xbug_pkg::OP_MUL1: begin
                mul_a = z_reg[63:32];
                mul_b = mul_const[31:0];
            end
            xbug_pkg::OP_MUL2: begin
                mul_a = z_reg[31:0];
                mul_b = mul_const[63:32];
            end
            default: begin
                mul_a = z_reg[31:0];
                mul_b = mul_const[31:0];
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    assign div_trial = {rem_reg, dvd_reg[63]};
    assign div_diff  = div_trial - {1'b0, bound_reg};

    // xoshiro256** output and state update
    assign m5       = gen_reg[1] + {gen_reg[1][61:0], 2'b00};
    assign rot7     = {m5[56:0], m5[63:57]};
    assign draw_out = rot7 + {rot7[60:0], 3'b000};
    assign x2       = gen_reg[2] ^ gen_reg[0];
    assign x3       = gen_reg[3] ^ gen_reg[1];

    always_comb begin
        walker_next = walker_reg;
        z_next      = z_reg;
        acc_next    = acc_reg;
        r_next      = r_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        valid_next  = valid_reg;
        for (int i = 0; i < 4; i++) begin
            gen_next[i] = gen_reg[i];
        end

        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end

        case (cmd.op)
            xbug_pkg::OP_SEED_INIT: begin
                walker_next = seed_reg;
            end
            xbug_pkg::OP_MIX1: begin
                walker_next = gamma_sum;
                z_next      = gamma_sum ^ (gamma_sum >> 30);
            end
            xbug_pkg::OP_MUL0: begin
                acc_next = prod;
            end
            xbug_pkg::OP_MUL1, xbug_pkg::OP_MUL2: begin
                acc_next = acc_reg + {prod[31:0], 32'd0};
            end
            xbug_pkg::OP_MIX2: begin
                z_next = acc_reg ^ (acc_reg >> 27);
            end
            xbug_pkg::OP_MIX3: begin
                gen_next[cmd.word_idx] = acc_reg ^ (acc_reg >> 31);
            end
            xbug_pkg::OP_DIV_THR: begin
                dvd_next = 64'd0 - 64'(bound_reg);
                rem_next = '0;
            end
            xbug_pkg::OP_DIV_RES: begin
                dvd_next = r_reg;
                rem_next = '0;
            end
            xbug_pkg::OP_DIV_STEP: begin
                dvd_next = {dvd_reg[62:0], 1'b0};
                if (div_trial >= {1'b0, bound_reg}) begin
                    rem_next = div_diff[BOUND_BITS-1:0];
                end else begin
                    rem_next = div_trial[BOUND_BITS-1:0];
                end
            end
            xbug_pkg::OP_DRAW: begin
                r_next      = draw_out;
                gen_next[2] = x2 ^ {gen_reg[1][46:0], 17'd0};
                gen_next[3] = {x3[18:0], x3[63:19]};
                gen_next[1] = gen_reg[1] ^ x2;
                gen_next[0] = gen_reg[0] ^ x3;
            end
            xbug_pkg::OP_OUT: begin
                valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            seed_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_fire) begin
                seed_reg <= cfg_seed_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        walker_reg <= walker_next;
        z_reg      <= z_next;
        acc_reg    <= acc_next;
        r_reg      <= r_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        for (int i = 0; i < 4; i++) begin
            gen_reg[i] <= gen_next[i];
        end
        if (cmd.op == xbug_pkg::OP_LOAD) begin
            bound_reg <= s_bound;
        end
        if (cmd.op == xbug_pkg::OP_SAVE_THR) begin
            thr_reg <= rem_reg;
        end
        if (cmd.op == xbug_pkg::OP_OUT) begin
            value_reg <= (bound_reg == '0) ? '0 : rem_reg;
        end
    end

    assign status.bound_zero = (bound_reg == '0);
    assign status.below_thr  = (r_reg < 64'(thr_reg));
    assign status.out_free   = !valid_reg || m_ready;

    assign m_valid = valid_reg;
    assign m_value = value_reg;

endmodule

// ===== design/xoshiro_bounded_uniform_generator_core.sv =====
// Top level of the bounded uniform xoshiro256** generator.
`timescale 1ns / 1ps
// Usage:
//   cfg_valid/cfg_ready carry a 64-bit seed word; it is taken only while the
//   block is idle and is expanded by splitmix64 on the next nonzero-bound draw.
//   s_valid/s_ready carry a bound word; m_valid/m_ready return one value word
//   in [0, bound), or 0 for a zero bound.
//   One word is worked on at a time. For a nonzero bound the time is set by
//   the shared radix-2 remainder unit, one bit a cycle, which finds the
//   threshold and then the remainder; a pending reseed first adds four
//   splitmix64 steps, each using a 32x32 multiplier.
//   The result sits in an output register; a new bound word is accepted while
//   it waits, and the next result is held back until the receiver takes it.
//   After reset the seed is 0 and a reseed is pending, so the first draw
//   expands seed 0.
module xoshiro_bounded_uniform_generator_core #(
    parameter int BOUND_BITS = xbug_pkg::BOUND_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [63:0]           cfg_seed_value,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BOUND_BITS-1:0] s_bound,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BOUND_BITS-1:0] m_value
);

    xbug_pkg::dp_cmd_t    cmd;
    xbug_pkg::dp_status_t status;
    logic                 cfg_fire;

    assign cfg_fire = cfg_valid && cfg_ready;

    xbug_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_fire  (cfg_fire),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    xbug_dp #(
        .BOUND_BITS (BOUND_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_bound        (s_bound),
        .cfg_fire       (cfg_fire),
        .cfg_seed_value (cfg_seed_value),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value)
    );

endmodule
